// File: design/mc_pkg.sv
// Morse codec package: types, character codes and code tree tables.
`timescale 1ns / 1ps
package mc_pkg;

    localparam int MAX_SYMBOLS_DEF = 6;
    localparam int POS_W           = 7;
    localparam int CNT_W           = 3;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    localparam logic [POS_W-1:0] ROOT_POS = 7'd1;

    typedef enum logic [1:0] {
        SYM_NONE = 2'd0,
        SYM_DOT  = 2'd1,
        SYM_DASH = 2'd2
    } t_symbol;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_UNKNOWN = 2'd2
    } t_status;

    // Decode walk state, one entry of the walk memory.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] cnt;
        logic             inv;
    } t_walk;

    localparam t_walk WALK_RESET = '{pos: ROOT_POS, cnt: '0, inv: 1'b0};

    // One item's worth of work for the result sequencer.
    typedef struct packed {
        logic             single;     // one fixed result, else a dot/dash path
        logic [CNT_W-1:0] count;      // results to send
        logic [POS_W-1:0] path;       // heap index, bits below the leading one are the code
        logic [7:0]       character;
        t_status          status;
    } t_desc;

    function automatic logic node_here(input logic [POS_W-1:0] idx);
        logic here;
        case (idx)
            7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10,
            7'd11, 7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17, 7'd18, 7'd19,
            7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28,
            7'd29, 7'd30, 7'd31, 7'd32, 7'd33, 7'd35, 7'd39, 7'd41, 7'd47,
            7'd48, 7'd56, 7'd60, 7'd62, 7'd63, 7'd82: here = 1'b1;
            default: here = 1'b0;
        endcase
        return here;
    endfunction

    function automatic logic [7:0] node_char(input logic [POS_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd2:  ch = "E";
            7'd3:  ch = "T";
            7'd4:  ch = "I";
            7'd5:  ch = "A";
            7'd6:  ch = "N";
            7'd7:  ch = "M";
            7'd8:  ch = "S";
            7'd9:  ch = "U";
            7'd10: ch = "R";
            7'd11: ch = "W";
            7'd12: ch = "D";
            7'd13: ch = "K";
            7'd14: ch = "G";
            7'd15: ch = "O";
            7'd16: ch = "H";
            7'd17: ch = "V";
            7'd18: ch = "F";
            7'd20: ch = "L";
            7'd22: ch = "P";
            7'd23: ch = "J";
            7'd24: ch = "B";
            7'd25: ch = "X";
            7'd26: ch = "C";
            7'd27: ch = "Y";
            7'd28: ch = "Z";
            7'd29: ch = "Q";
            7'd32: ch = "5";
            7'd33: ch = "4";
            7'd35: ch = "3";
            7'd39: ch = "2";
            7'd47: ch = "1";
            7'd48: ch = "6";
            7'd56: ch = "7";
            7'd60: ch = "8";
            7'd62: ch = "9";
            7'd63: ch = "0";
            7'd82: ch = " ";
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Reverse lookup: character to tree node, 0 when absent.
    function automatic logic [POS_W-1:0] char_node(input logic [7:0] ch);
        logic [POS_W-1:0] idx;
        case (ch)
            "E": idx = 7'd2;
            "T": idx = 7'd3;
            "I": idx = 7'd4;
            "A": idx = 7'd5;
            "N": idx = 7'd6;
            "M": idx = 7'd7;
            "S": idx = 7'd8;
            "U": idx = 7'd9;
            "R": idx = 7'd10;
            "W": idx = 7'd11;
            "D": idx = 7'd12;
            "K": idx = 7'd13;
            "G": idx = 7'd14;
            "O": idx = 7'd15;
            "H": idx = 7'd16;
            "V": idx = 7'd17;
            "F": idx = 7'd18;
            "L": idx = 7'd20;
            "P": idx = 7'd22;
            "J": idx = 7'd23;
            "B": idx = 7'd24;
            "X": idx = 7'd25;
            "C": idx = 7'd26;
            "Y": idx = 7'd27;
            "Z": idx = 7'd28;
            "Q": idx = 7'd29;
            "5": idx = 7'd32;
            "4": idx = 7'd33;
            "3": idx = 7'd35;
            "2": idx = 7'd39;
            "1": idx = 7'd47;
            "6": idx = 7'd48;
            "7": idx = 7'd56;
            "8": idx = 7'd60;
            "9": idx = 7'd62;
            "0": idx = 7'd63;
            " ": idx = 7'd82;
            default: idx = '0;
        endcase
        return idx;
    endfunction

    // Depth of a heap index = position of its leading one.
    function automatic logic [CNT_W-1:0] node_depth(input logic [POS_W-1:0] idx);
        logic [CNT_W-1:0] d;
        if (idx[6]) begin
            d = 3'd6;
        end else if (idx[5]) begin
            d = 3'd5;
        end else if (idx[4]) begin
            d = 3'd4;
        end else if (idx[3]) begin
            d = 3'd3;
        end else if (idx[2]) begin
            d = 3'd2;
        end else if (idx[1]) begin
            d = 3'd1;
        end else begin
            d = 3'd0;
        end
        return d;
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] ch);
        logic [7:0] r;
        if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
            r = ch - CASE_OFS;
        end else begin
            r = ch;
        end
        return r;
    endfunction

endpackage

// File: design/mc_if.sv
// Morse codec channel interfaces: input byte channel and result channel.
`timescale 1ns / 1ps
interface mc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_text;

    modport source (output valid, output byte_in, output end_of_text, input ready);
    modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface mc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic [1:0] symbol;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output character, output symbol, output status,
                    output last, input ready);
    modport sink   (input valid, input character, input symbol, input status,
                    input last, output ready);
endinterface

// File: design/mc_walk.sv
// Morse codec walk stage: walk state memory, tree step and item decode.
`timescale 1ns / 1ps
module mc_walk #(
    parameter int MAX_SYMBOLS = mc_pkg::MAX_SYMBOLS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_direction,
    mc_in_if.sink         i_in,
    output mc_pkg::t_desc o_desc,
    output logic          o_desc_valid,
    input  logic          i_desc_ready
);

    localparam logic [mc_pkg::CNT_W-1:0] MAX_CNT = mc_pkg::CNT_W'(MAX_SYMBOLS);

    // walk state memory, one entry, synchronous read
    mc_pkg::t_walk r_mem [1];
    logic          r_mem_vld;
    mc_pkg::t_walk r_rd;

    logic       r_s1_valid;
    logic [7:0] r_byte;
    logic       r_eot;
    logic       r_dir;

    logic                        w_accept;
    logic                        w_fire;
    logic                        w_no_result;
    logic                        w_wr_en;
    logic                        w_dot;
    logic                        w_dash;
    logic                        w_flush;
    logic [mc_pkg::POS_W-1:0]    w_next;
    mc_pkg::t_walk               w_step;
    mc_pkg::t_walk               n_walk;
    logic [7:0]                  w_uc;
    logic [mc_pkg::POS_W-1:0]    w_idx;
    logic [mc_pkg::CNT_W-1:0]    w_depth;
    mc_pkg::t_desc               w_desc;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_no_result = !r_dir && !w_flush;
    assign w_fire      = r_s1_valid && (w_no_result || i_desc_ready);
    assign i_in.ready  = !r_s1_valid || w_fire;
    assign w_wr_en     = w_fire && !r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_mem_vld  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (w_wr_en) begin
                r_mem_vld <= 1'b1;
            end
        end
    end

    // memory port: write back, read with write-first forwarding
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[0] <= n_walk;
        end
        if (w_accept) begin
            if (w_wr_en) begin
                r_rd <= n_walk;
            end else if (r_mem_vld) begin
                r_rd <= r_mem[0];
            end else begin
                r_rd <= mc_pkg::WALK_RESET;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_in.byte_in;
            r_eot  <= i_in.end_of_text;
            r_dir  <= i_direction;
        end
    end

    // decode: one tree step, then optional flush
    assign w_dot   = (r_byte == mc_pkg::CH_DOT);
    assign w_dash  = (r_byte == mc_pkg::CH_DASH);
    assign w_flush = (r_byte == mc_pkg::CH_SPACE) || r_eot;
    assign w_next  = {r_rd.pos[mc_pkg::POS_W-2:0], w_dash};

    always_comb begin
        w_step = r_rd;
        if ((w_dot || w_dash) && !r_rd.inv) begin
            if (r_rd.cnt >= MAX_CNT || r_rd.pos[mc_pkg::POS_W-1]) begin
                w_step.inv = 1'b1;
            end else if (!mc_pkg::node_here(w_next)) begin
                w_step.inv = 1'b1;
            end else begin
                w_step.pos = w_next;
                w_step.cnt = r_rd.cnt + 1'b1;
            end
        end
    end

    assign n_walk = w_flush ? mc_pkg::WALK_RESET : w_step;

    // encode lookup
    assign w_uc    = mc_pkg::upcase(r_byte);
    assign w_idx   = mc_pkg::char_node(w_uc);
    assign w_depth = mc_pkg::node_depth(w_idx);

    always_comb begin
        w_desc.single    = 1'b1;
        w_desc.count     = mc_pkg::CNT_W'(1);
        w_desc.path      = '0;
        w_desc.character = mc_pkg::CH_NUL;
        w_desc.status    = mc_pkg::ST_OK;
        if (!r_dir) begin
            if (w_step.inv) begin
                w_desc.status = mc_pkg::ST_INVALID;
            end else begin
                w_desc.character = mc_pkg::node_char(w_step.pos);
            end
        end else if (w_uc == mc_pkg::CH_NUL) begin
            w_desc.status = mc_pkg::ST_OK;
        end else if (w_idx == '0 || w_depth > MAX_CNT) begin
            w_desc.status = mc_pkg::ST_UNKNOWN;
        end else begin
            w_desc.single = 1'b0;
            w_desc.count  = w_depth;
            w_desc.path   = w_idx;
        end
    end

    assign o_desc       = w_desc;
    assign o_desc_valid = r_s1_valid && !w_no_result;

endmodule

// File: design/mc_emit.sv
// Morse codec result sequencer: one result per cycle into the output register while the output is not stalled.
`timescale 1ns / 1ps
module mc_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mc_pkg::t_desc i_desc,
    input  logic          i_desc_valid,
    output logic          o_desc_ready,
    mc_out_if.source      o_out
);

    mc_pkg::t_desc            r_cur;
    logic                     r_cur_valid;
    logic [mc_pkg::CNT_W-1:0] r_rem;

    logic       r_out_valid;
    logic [7:0] r_character;
    logic [1:0] r_symbol;
    logic [1:0] r_status;
    logic       r_last;

    logic                     w_load_ok;
    logic                     w_emit;
    logic                     w_done;
    logic                     w_take;
    logic [mc_pkg::CNT_W-1:0] w_bit_sel;
    mc_pkg::t_symbol          w_sym;

    assign w_load_ok    = !r_out_valid || o_out.ready;
    assign w_emit       = r_cur_valid && w_load_ok;
    assign w_done       = w_emit && (r_rem == mc_pkg::CNT_W'(1));
    assign o_desc_ready = !r_cur_valid || w_done;
    assign w_take       = i_desc_valid && o_desc_ready;

    assign w_bit_sel = r_rem - 1'b1;
    assign w_sym     = r_cur.path[w_bit_sel] ? mc_pkg::SYM_DASH : mc_pkg::SYM_DOT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_cur_valid <= 1'b1;
            end else if (w_done) begin
                r_cur_valid <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cur <= i_desc;
            r_rem <= i_desc.count;
        end else if (w_emit) begin
            r_rem <= r_rem - 1'b1;
        end
        if (w_emit) begin
            if (r_cur.single) begin
                r_character <= r_cur.character;
                r_symbol    <= mc_pkg::SYM_NONE;
                r_status    <= r_cur.status;
                r_last      <= 1'b1;
            end else begin
                r_character <= mc_pkg::CH_NUL;
                r_symbol    <= w_sym;
                r_status    <= mc_pkg::ST_OK;
                r_last      <= (r_rem == mc_pkg::CNT_W'(1));
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_character;
    assign o_out.symbol    = r_symbol;
    assign o_out.status    = r_status;
    assign o_out.last      = r_last;

endmodule

// File: design/morse_codec_core.sv
// Morse codec top level: direction register, walk stage and result sequencer.
// Each byte is registered in the walk stage; one with a result then becomes the
// sequencer's item, which fills the output register. Decode takes a byte every cycle
// unless results stall; encode sends one symbol per cycle when not stalled (1 to 6 per byte, its code length).
// Reset (i_rst_n low, synchronous): direction = decode, walk at the root,
// pipeline and output register empty.
`timescale 1ns / 1ps
module morse_codec_core #(
    parameter int MAX_SYMBOLS = mc_pkg::MAX_SYMBOLS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_wr_en,
    input  logic     i_cfg_wr_data,
    mc_in_if.sink    i_in,
    mc_out_if.source o_out
);

    // direction: 0 decodes dot/dash text, 1 encodes characters
    logic r_direction;

    // walk stage -> sequencer
    mc_pkg::t_desc w_desc;
    logic          w_desc_valid;
    logic          w_desc_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_direction <= i_cfg_wr_data;
        end
    end

    // Walk stage: reads the walk entry on input transfer, steps the tree the
    // next cycle and writes back when a decode item leaves. Bytes that produce no
    // result (dots, dashes, other bytes without flush) retire there.
    mc_walk #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_direction  (r_direction),
        .i_in         (i_in),
        .o_desc       (w_desc),
        .o_desc_valid (w_desc_valid),
        .i_desc_ready (w_desc_ready)
    );

    // Sequencer: turns one item into its results, one per cycle while the output is not stalled.
    mc_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (w_desc),
        .i_desc_valid (w_desc_valid),
        .o_desc_ready (w_desc_ready),
        .o_out        (o_out)
    );

    // a stalled handoff to the sequencer must hold off new input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_desc_valid && !w_desc_ready) |-> !i_in.ready)
        else $error("input taken while walk stage is blocked");

    // symbol results come from encoding and never carry a character
    a_sym_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.symbol != mc_pkg::SYM_NONE) |-> (o_out.character == 8'h00))
        else $error("symbol result with nonzero character");

    // error results stand alone: last, no symbol
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != mc_pkg::ST_OK)
            |-> (o_out.last && o_out.symbol == mc_pkg::SYM_NONE))
        else $error("error result not a single final result");

endmodule

// File: verif/morse_codec_core_tb.sv
// Testbench for morse_codec_core: self-checking decode and encode runs with random handshakes.
`timescale 1ns / 1ps
module morse_codec_core_tb;

    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    // Pipeline settle time: covers the path through the block plus margin for
    // decode bytes that never produce a result.
    localparam int SETTLE_CYCLES = 8;

    // One result transfer as the predictor expects it.
    typedef struct packed {
        logic [7:0]      character;
        mc_pkg::t_symbol symbol;
        mc_pkg::t_status status;
        logic            last;
    } t_codec_result;

    // Tracks the codec's direction and decode walk, keeps the queue of
    // results still owed by the block and checks each result transfer.
    class codec_tracker;
        bit [127:0]    node_exists;
        logic [7:0]    node_letter [128];
        bit            encode_mode;
        int            walk_pos;
        int            walk_len;
        bit            walk_bad;
        t_codec_result owed_results[$];
        int unsigned   error_count;

        function new();
            // Heap order for nodes 2..31; '*' marks a node that exists but is empty.
            string upper_levels = "ETIANMSURWDKGOHVF*L*PJBXCYZQ**";
            node_exists = '0;
            for (int i = 0; i < 128; i++) begin
                node_letter[i] = mc_pkg::CH_NUL;
            end
            node_exists[1] = 1'b1;
            for (int i = 0; i < upper_levels.len(); i++) begin
                node_exists[i + 2] = 1'b1;
                node_letter[i + 2] = (upper_levels[i] == "*") ? mc_pkg::CH_NUL
                                                              : upper_levels[i];
            end
            add_node(32, "5");
            add_node(33, "4");
            add_node(35, "3");
            add_node(39, "2");
            add_node(41, mc_pkg::CH_NUL);
            add_node(47, "1");
            add_node(48, "6");
            add_node(56, "7");
            add_node(60, "8");
            add_node(62, "9");
            add_node(63, "0");
            add_node(82, mc_pkg::CH_SPACE);
            encode_mode = 1'b0;
            error_count = 0;
            clear_walk();
        endfunction

        function void add_node(int idx, logic [7:0] letter);
            node_exists[idx] = 1'b1;
            node_letter[idx] = letter;
        endfunction

        function void clear_walk();
            walk_pos = 1;
            walk_len = 0;
            walk_bad = 1'b0;
        endfunction

        function void owe(logic [7:0] ch, mc_pkg::t_symbol sym, mc_pkg::t_status st,
                          logic lst);
            t_codec_result r;
            r.character = ch;
            r.symbol    = sym;
            r.status    = st;
            r.last      = lst;
            owed_results.push_back(r);
        endfunction

        // One dot (0) or dash (1) step of the decode walk.
        function void walk_step(int dash);
            int nxt;
            if (walk_bad) begin
                return;
            end
            if (walk_len >= mc_pkg::MAX_SYMBOLS_DEF || walk_pos >= 64) begin
                walk_bad = 1'b1;
                return;
            end
            nxt = walk_pos * 2 + dash;
            if (nxt >= 128 || !node_exists[nxt]) begin
                walk_bad = 1'b1;
                return;
            end
            walk_pos = nxt;
            walk_len++;
        endfunction

        function void encode_char(logic [7:0] b);
            logic [7:0] c;
            int idx;
            int depth;
            c = b;
            if (c >= mc_pkg::CH_LO_A && c <= mc_pkg::CH_LO_Z) begin
                c = c - mc_pkg::CASE_OFS;
            end
            // NUL sits at the root: a single empty symbol.
            if (c == mc_pkg::CH_NUL) begin
                owe(mc_pkg::CH_NUL, mc_pkg::SYM_NONE, mc_pkg::ST_OK, 1'b1);
                return;
            end
            idx = 0;
            for (int i = 2; i < 128; i++) begin
                if (node_exists[i] && node_letter[i] == c) begin
                    idx = i;
                    break;
                end
            end
            depth = 0;
            for (int i = idx; i > 1; i = i >> 1) begin
                depth++;
            end
            if (idx == 0 || depth > mc_pkg::MAX_SYMBOLS_DEF) begin
                owe(mc_pkg::CH_NUL, mc_pkg::SYM_NONE, mc_pkg::ST_UNKNOWN, 1'b1);
                return;
            end
            // Path bits below the leading one, msb first.
            for (int k = depth; k > 0; k--) begin
                owe(mc_pkg::CH_NUL,
                    ((idx >> (k - 1)) & 1) ? mc_pkg::SYM_DASH : mc_pkg::SYM_DOT,
                    mc_pkg::ST_OK, k == 1);
            end
        endfunction

        // Called for every accepted input transfer.
        function void note_byte(logic [7:0] b, logic eot);
            if (encode_mode) begin
                encode_char(b);
                return;
            end
            if (b == mc_pkg::CH_DOT) begin
                walk_step(0);
            end else if (b == mc_pkg::CH_DASH) begin
                walk_step(1);
            end
            // Space and end of text flush once, even when both are present.
            if (b == mc_pkg::CH_SPACE || eot) begin
                if (walk_bad) begin
                    owe(mc_pkg::CH_NUL, mc_pkg::SYM_NONE, mc_pkg::ST_INVALID, 1'b1);
                end else begin
                    owe(node_letter[walk_pos], mc_pkg::SYM_NONE, mc_pkg::ST_OK, 1'b1);
                end
                clear_walk();
            end
        endfunction

        // Called for every accepted result transfer.
        function void check_result(logic [7:0] ch, logic [1:0] sym, logic [1:0] st,
                                   logic lst);
            t_codec_result want;
            if (owed_results.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("unexpected result: ch=%h sym=%0d st=%0d last=%0d",
                             ch, sym, st, lst);
                end
                return;
            end
            want = owed_results.pop_front();
            if (want.character !== ch || want.symbol !== sym || want.status !== st ||
                want.last !== lst) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("mismatch: expected ch=%h sym=%0d st=%0d last=%0d,",
                             want.character, want.symbol, want.status, want.last,
                             " got ch=%h sym=%0d st=%0d last=%0d",
                             ch, sym, st, lst);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    mc_in_if  in_ch();
    mc_out_if out_ch();

    codec_tracker tracker = new();

    int          send_idle_pct = 16;
    int          recv_idle_pct = 60;
    int unsigned items_sent    = 0;
    int          quiet_cycles  = 0;

    morse_codec_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checking and hang watchdog, sampled on the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                tracker.check_result(out_ch.character, out_ch.symbol, out_ch.status,
                                     out_ch.last);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Drives one byte; returns at the rising edge of its transfer with valid
    // still high, so the next call can keep it up without a glitch.
    task automatic send_byte(logic [7:0] b, logic eot);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid       <= 1'b0;
            in_ch.byte_in     <= 8'($urandom);
            in_ch.end_of_text <= 1'($urandom);
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.byte_in     <= b;
        in_ch.end_of_text <= eot;
        @(posedge clk);
        while (!in_ch.ready) begin
            @(posedge clk);
        end
        tracker.note_byte(b, eot);
        items_sent++;
    endtask

    task automatic send_text(string s, logic eot_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], eot_last && (i == s.len() - 1));
        end
    endtask

    // Dot/dash path of a tree node, optionally ending the text on its last symbol.
    task automatic send_path(int node, logic eot_on_last);
        int depth;
        depth = 0;
        for (int i = node; i > 1; i = i >> 1) begin
            depth++;
        end
        for (int k = depth; k > 0; k--) begin
            send_byte(((node >> (k - 1)) & 1) ? mc_pkg::CH_DASH : mc_pkg::CH_DOT,
                      eot_on_last && k == 1);
        end
    endtask

    // Drop valid, wait for every owed result, then let the pipeline settle
    // so a trailing decode byte with no result is out of the block too.
    task automatic wait_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (tracker.owed_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_direction(logic dir);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= dir;
        @(posedge clk);
        tracker.encode_mode = dir;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_decode(int unsigned n_items);
        int unsigned stop_at;
        int          roll;
        int          node;
        int          run_len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            node = $urandom_range(127, 1);
            while (!tracker.node_exists[node]) begin
                node = $urandom_range(127, 1);
            end
            if (roll < 70) begin
                // Well-formed code word with a random terminator.
                case ($urandom_range(3))
                    0, 1: begin
                        send_path(node, 1'b0);
                        send_byte(mc_pkg::CH_SPACE, 1'b0);
                    end
                    2: begin
                        send_path(node, 1'b0);
                        send_byte(mc_pkg::CH_SPACE, 1'b1);
                    end
                    default: begin
                        send_path(node, 1'b1);
                    end
                endcase
            end else if (roll < 80) begin
                // Long random run, often past the tree depth.
                run_len = $urandom_range(9, 5);
                for (int i = 0; i < run_len; i++) begin
                    send_byte($urandom_range(1) ? mc_pkg::CH_DASH : mc_pkg::CH_DOT, 1'b0);
                end
                send_byte(mc_pkg::CH_SPACE, $urandom_range(3) == 0);
            end else if (roll < 88) begin
                // Code word broken by a random byte.
                send_path(node, 1'b0);
                send_byte(8'($urandom), $urandom_range(4) == 0);
            end else begin
                case ($urandom_range(3))
                    0:       send_byte(mc_pkg::CH_DOT, $urandom_range(4) == 0);
                    1:       send_byte(mc_pkg::CH_DASH, $urandom_range(4) == 0);
                    2:       send_byte(mc_pkg::CH_SPACE, $urandom_range(4) == 0);
                    default: send_byte(8'($urandom), $urandom_range(4) == 0);
                endcase
            end
        end
    endtask

    task automatic random_encode(int unsigned n_items);
        string       alphabet = "ETIANMSURWDKGOHVFLPJBXCYZQ0123456789 ";
        int unsigned stop_at;
        int          roll;
        logic [7:0]  c;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                c = alphabet[$urandom_range(alphabet.len() - 1)];
                if (c >= "A" && c <= "Z" && $urandom_range(1)) begin
                    c = c + mc_pkg::CASE_OFS;
                end
            end else if (roll < 75) begin
                c = mc_pkg::CH_NUL;
            end else begin
                c = 8'($urandom);
            end
            send_byte(c, $urandom_range(7) == 0);
        end
    endtask

    initial begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.byte_in      = 8'h00;
        in_ch.end_of_text  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed decode: space node, empty node, empty flush, missing branch,
        // too many symbols, ignored byte with a walk left open.
        write_direction(1'b0);
        send_text(".-..-. ", 1'b0);
        send_text("..--", 1'b1);
        send_text(" ", 1'b1);
        send_text("..-.-", 1'b1);
        send_text(".-..-.-", 1'b1);
        send_text("-x.", 1'b0);
        wait_drained();

        // Directed encode: NUL, lower case, six-symbol space, digit, unknowns.
        write_direction(1'b1);
        send_byte(8'h00, 1'b0);
        send_byte("a", 1'b0);
        send_byte(mc_pkg::CH_SPACE, 1'b1);
        send_byte("0", 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(mc_pkg::CH_DOT, 1'b0);
        wait_drained();

        // The open "-." walk survives the direction changes: flush gives N.
        write_direction(1'b0);
        send_byte(mc_pkg::CH_SPACE, 1'b0);

        // Random phases: sender-light, receiver-light, then full rate.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 60 : 0;
            recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 16 : 0;
            wait_drained();
            write_direction(1'b0);
            random_decode(80);
            wait_drained();
            write_direction(1'b1);
            random_encode(60);
        end
        wait_drained();

        if (tracker.error_count == 0 && tracker.owed_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
